FILE: sv/lru_key_value_cache_core_assert.svh
// Assertion macros used by the cache core's datapath (lkvc_dp.sv).
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lkvc_pkg.sv
// Package with the shared types and constants of the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_VALUE_BITS = 16;

    localparam int CFG_BITS = 7;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic upd_mode;
        logic decide;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic need_update;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/lru_key_value_cache_core.sv
// Items are handled one at a time: a new item is taken only after the previous one has
// reached the output register. Each item costs a linear scan of the key and rank memories
// (one read port each) and, for a hit or a put, a read-modify-write pass over the rank
// memory; a get miss skips that pass.
// A new item is taken while the previous result still waits in the output register.
// Reset: rst_n is asynchronous, active low; the cache comes up empty, capacity 64, no clearing.
`default_nettype none

module lru_key_value_cache_core #(
    parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write channel: capacity in use before inserts evict.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lkvc_pkg::CFG_BITS-1:0] entries_in_use,
    // Request channel.
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic [KEY_BITS-1:0]           key,
    input  wire logic [VALUE_BITS-1:0]         value,
    // Result channel.
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               hit,
    output logic      [VALUE_BITS-1:0]         read_value,
    output logic                               evicted
);

    import lkvc_pkg::*;

    // The controller walks each item through four phases, of which a get miss skips update:
    //   scan   - every occupied slot is read; the first key match and the
    //            least recent slot (highest rank) are recorded,
    //   decide - the hit, update, insert or eviction is chosen and the key
    //            and value memories are written or read,
    //   update - every affected rank is read, aged and written back, with
    //            the touched or new slot set to most recent,
    //   done   - the result is loaded into the output register as soon as
    //            the previous result has been transferred.
    // Valid slots always fill 0 .. occupancy-1, so the occupancy count is the
    // only valid state and the memories need no reset.

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Always ready; the user must issue configuration writes only while idle (unchecked).
    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lkvc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .entries_in_use (entries_in_use),
        .action         (action),
        .key            (key),
        .value          (value),
        .hit            (hit),
        .read_value     (read_value),
        .evicted        (evicted),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

`default_nettype wire

FILE: sv/lkvc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/lkvc_ctrl.sv
// Controller state machine that sequences the scan, decision and rank update of one item.
`default_nettype none

module lkvc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire lkvc_pkg::dp_status_t status,
    output lkvc_pkg::ctrl_cmd_t      cmd
);

    import lkvc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = status.need_update ? ST_UPDATE : ST_DONE;
            end
            ST_UPDATE:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.step     = 1'b1;
                cmd.upd_mode = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/lkvc_dp.sv
// Datapath: key, value and rank memories, scan compare, replacement choice and result register.
`default_nettype none
`include "lru_key_value_cache_core_assert.svh"

module lkvc_dp #(
    parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [lkvc_pkg::CFG_BITS-1:0] entries_in_use,
    input  wire logic                          action,
    input  wire logic [KEY_BITS-1:0]           key,
    input  wire logic [VALUE_BITS-1:0]         value,
    output logic                               hit,
    output logic      [VALUE_BITS-1:0]         read_value,
    output logic                               evicted,
    input  wire lkvc_pkg::ctrl_cmd_t           cmd,
    output lkvc_pkg::dp_status_t               status
);

    import lkvc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

    // Item registers.
    logic                  act_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    logic [CFG_BITS-1:0]   cfg_reg,        cfg_next;
    logic [CNT_W-1:0]      occ_reg,        occ_next;
    logic [CNT_W-1:0]      rd_cnt_reg,     rd_cnt_next;
    logic                  pipe_vld_reg,   pipe_vld_next;
    logic [IDX_W-1:0]      pipe_idx_reg,   pipe_idx_next;
    logic                  hit_reg,        hit_next;
    logic [IDX_W-1:0]      found_idx_reg,  found_idx_next;
    logic [RANK_W-1:0]     found_rank_reg, found_rank_next;
    logic                  any_reg,        any_next;
    logic [IDX_W-1:0]      victim_reg,     victim_next;
    logic [RANK_W-1:0]     max_rank_reg,   max_rank_next;
    logic [IDX_W-1:0]      tgt_reg,        tgt_next;
    logic [RANK_W-1:0]     old_rank_reg,   old_rank_next;
    logic                  age_all_reg,    age_all_next;
    logic [CNT_W-1:0]      upd_limit_reg,  upd_limit_next;
    logic                  ev_reg,         ev_next;
    logic                  val_pend_reg,   val_pend_next;
    logic [VALUE_BITS-1:0] rd_value_reg,   rd_value_next;
    logic                  out_hit_reg,    out_hit_next;
    logic [VALUE_BITS-1:0] out_rd_reg,     out_rd_next;
    logic                  out_ev_reg,     out_ev_next;

    logic [CNT_W-1:0]      limit;
    logic                  issue;
    logic [IDX_W-1:0]      rd_idx;
    logic [CMP_W-1:0]      occ_ext;
    logic [CMP_W-1:0]      cap_ext;
    logic                  full;
    logic [IDX_W-1:0]      ins_slot;
    logic                  is_put;

    logic [KEY_BITS-1:0]   key_q;
    logic [VALUE_BITS-1:0] val_q;
    logic [RANK_W-1:0]     rank_q;
    logic                  key_we;
    logic                  val_we;
    logic [IDX_W-1:0]      val_addr;
    logic                  rank_we;
    logic [RANK_W-1:0]     rank_new;

    assign is_put  = (act_reg == ACT_PUT);
    assign limit   = cmd.upd_mode ? upd_limit_reg : occ_reg;
    assign issue   = cmd.step && (rd_cnt_reg < limit);
    assign rd_idx  = rd_cnt_reg[IDX_W-1:0];

    // An out-of-range capacity is clamped: zero acts as one, above ENTRIES acts as ENTRIES.
    assign occ_ext = CMP_W'(occ_reg);
    assign cap_ext = (cfg_reg == '0) ? CMP_W'(1) : CMP_W'(cfg_reg);
    assign full    = (occ_ext >= cap_ext) || (occ_ext >= CMP_W'(ENTRIES));

    assign ins_slot = full ? victim_reg : occ_reg[IDX_W-1:0];
    assign key_we   = cmd.decide && is_put && !hit_reg;
    assign val_we   = cmd.decide && is_put;
    assign val_addr = hit_reg ? found_idx_reg : ins_slot;

    assign rank_we  = pipe_vld_reg && cmd.upd_mode;
    always_comb
    begin
        if (pipe_idx_reg == tgt_reg)
        begin
            rank_new = '0;
        end
        else if (age_all_reg || (rank_q < old_rank_reg))
        begin
            rank_new = rank_q + RANK_W'(1);
        end
        else
        begin
            rank_new = rank_q;
        end
    end

    lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .clk     (clk),
        .we      (key_we),
        .wr_addr (ins_slot),
        .wr_data (key_reg),
        .rd_addr (rd_idx),
        .rd_data (key_q)
    );

    lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
        .clk     (clk),
        .we      (val_we),
        .wr_addr (val_addr),
        .wr_data (val_reg),
        .rd_addr (found_idx_reg),
        .rd_data (val_q)
    );

    lkvc_ram #(.WIDTH(RANK_W), .DEPTH(ENTRIES)) u_rank_ram (
        .clk     (clk),
        .we      (rank_we),
        .wr_addr (pipe_idx_reg),
        .wr_data (rank_new),
        .rd_addr (rd_idx),
        .rd_data (rank_q)
    );

    always_comb
    begin
        cfg_next        = cfg_reg;
        occ_next        = occ_reg;
        rd_cnt_next     = rd_cnt_reg;
        pipe_vld_next   = issue;
        pipe_idx_next   = rd_idx;
        hit_next        = hit_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        any_next        = any_reg;
        victim_next     = victim_reg;
        max_rank_next   = max_rank_reg;
        tgt_next        = tgt_reg;
        old_rank_next   = old_rank_reg;
        age_all_next    = age_all_reg;
        upd_limit_next  = upd_limit_reg;
        ev_next         = ev_reg;
        val_pend_next   = cmd.decide && (act_reg == ACT_GET) && hit_reg;
        rd_value_next   = rd_value_reg;
        out_hit_next    = out_hit_reg;
        out_rd_next     = out_rd_reg;
        out_ev_next     = out_ev_reg;

        if (cfg_valid)
        begin
            cfg_next = entries_in_use;
        end

        if (issue)
        begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end

        if (cmd.load)
        begin
            rd_cnt_next   = '0;
            hit_next      = 1'b0;
            any_next      = 1'b0;
            ev_next       = 1'b0;
            rd_value_next = '0;
        end

        // Scan compare stage: first matching key, and the highest rank as the victim.
        if (pipe_vld_reg && !cmd.upd_mode)
        begin
            if (!hit_reg && (key_q == key_reg))
            begin
                hit_next        = 1'b1;
                found_idx_next  = pipe_idx_reg;
                found_rank_next = rank_q;
            end
            if (!any_reg || (rank_q > max_rank_reg))
            begin
                any_next      = 1'b1;
                victim_next   = pipe_idx_reg;
                max_rank_next = rank_q;
            end
        end

        if (cmd.decide)
        begin
            rd_cnt_next    = '0;
            age_all_next   = 1'b0;
            upd_limit_next = occ_reg;
            if (hit_reg)
            begin
                tgt_next      = found_idx_reg;
                old_rank_next = found_rank_reg;
            end
            else if (is_put && full)
            begin
                tgt_next      = victim_reg;
                old_rank_next = max_rank_reg;
                ev_next       = 1'b1;
            end
            else if (is_put)
            begin
                // The new slot joins the pass so that its rank is written as zero.
                tgt_next       = occ_reg[IDX_W-1:0];
                age_all_next   = 1'b1;
                upd_limit_next = occ_reg + CNT_W'(1);
                occ_next       = occ_reg + CNT_W'(1);
            end
        end

        if (val_pend_reg)
        begin
            rd_value_next = val_q;
        end

        if (cmd.emit)
        begin
            out_hit_next = hit_reg;
            out_rd_next  = val_pend_reg ? val_q : rd_value_reg;
            out_ev_next  = ev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_RESET;
            occ_reg        <= '0;
            rd_cnt_reg     <= '0;
            pipe_vld_reg   <= 1'b0;
            pipe_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            found_idx_reg  <= '0;
            found_rank_reg <= '0;
            any_reg        <= 1'b0;
            victim_reg     <= '0;
            max_rank_reg   <= '0;
            tgt_reg        <= '0;
            old_rank_reg   <= '0;
            age_all_reg    <= 1'b0;
            upd_limit_reg  <= '0;
            ev_reg         <= 1'b0;
            val_pend_reg   <= 1'b0;
            rd_value_reg   <= '0;
            out_hit_reg    <= 1'b0;
            out_rd_reg     <= '0;
            out_ev_reg     <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            occ_reg        <= occ_next;
            rd_cnt_reg     <= rd_cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            pipe_idx_reg   <= pipe_idx_next;
            hit_reg        <= hit_next;
            found_idx_reg  <= found_idx_next;
            found_rank_reg <= found_rank_next;
            any_reg        <= any_next;
            victim_reg     <= victim_next;
            max_rank_reg   <= max_rank_next;
            tgt_reg        <= tgt_next;
            old_rank_reg   <= old_rank_next;
            age_all_reg    <= age_all_next;
            upd_limit_reg  <= upd_limit_next;
            ev_reg         <= ev_next;
            val_pend_reg   <= val_pend_next;
            rd_value_reg   <= rd_value_next;
            out_hit_reg    <= out_hit_next;
            out_rd_reg     <= out_rd_next;
            out_ev_reg     <= out_ev_next;
        end
    end

    assign status.pass_done   = (rd_cnt_reg >= limit) && !pipe_vld_reg;
    assign status.need_update = hit_reg || is_put;

    assign hit        = out_hit_reg;
    assign read_value = out_rd_reg;
    assign evicted    = out_ev_reg;

    `LKVC_ASSERT_NOW(a_occ_bound, 1'b1, occ_ext <= CMP_W'(ENTRIES), "occupancy above entry count")
    `LKVC_ASSERT_NEXT(a_occ_hold, !cmd.decide, $stable(occ_reg), "occupancy changed outside decide")
    `LKVC_ASSERT_NOW(a_hit_slot, hit_reg, CNT_W'(found_idx_reg) < occ_reg, "hit slot not occupied")
    `LKVC_ASSERT_NOW(a_out_excl, out_hit_reg, !out_ev_reg, "result shows both hit and eviction")

endmodule

`default_nettype wire
